// ===== src/ansi_escape_terminal_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the aetp_ctl parser module.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_TERMINAL_PARSER_MACROS_SVH
`define ANSI_ESCAPE_TERMINAL_PARSER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define AETP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define AETP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/aetp_pkg.sv =====
// ----------------------------------------------------------------------------
// aetp_pkg
// Types, constants and helper functions of the ANSI escape terminal parser.
// ----------------------------------------------------------------------------
package aetp_pkg;

   // Screen size limits.
   localparam int COLS = 256;
   localparam int ROWS = 1024;

   localparam int BYTE_W  = 8;
   localparam int COL_W   = 8;
   localparam int ROW_W   = 10;
   localparam int CLR_W   = 3;
   localparam int PARAM_W = 14;
   localparam int TAB_W   = 5;
   localparam int REM_W   = 4;
   localparam int CNT_W   = 5;
   localparam int ALU_W   = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam int COL_MAX   = (COLS < 256)  ? COLS - 1 : 255;
   localparam int ROW_MAX   = (ROWS < 1024) ? ROWS - 1 : 1023;
   localparam int PARAM_MAX = 16383;
   localparam int TAB_MAX   = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_FG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_BG = 2'd2;

   localparam logic [TAB_W-1:0] TAB_WIDTH_RST  = 5'd8;
   localparam logic [CLR_W-1:0] DEFAULT_FG_RST = 3'd7;
   localparam logic [CLR_W-1:0] DEFAULT_BG_RST = 3'd0;

   // Byte codes.
   localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CH_SGR    = 8'h6D;
   localparam logic [BYTE_W-1:0] CH_J      = 8'h4A;
   localparam logic [BYTE_W-1:0] CH_K      = 8'h4B;
   localparam logic [BYTE_W-1:0] CH_UP     = 8'h41;
   localparam logic [BYTE_W-1:0] CH_DOWN   = 8'h42;
   localparam logic [BYTE_W-1:0] CH_RIGHT  = 8'h43;
   localparam logic [BYTE_W-1:0] CH_LEFT   = 8'h44;
   localparam logic [BYTE_W-1:0] CH_NULL   = 8'h00;

   typedef enum logic [1:0] {
      MODE_TEXT    = 2'd0,
      MODE_ESC     = 2'd1,
      MODE_CSI     = 2'd2,
      MODE_CHARSET = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_TRUNC = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_TABCNT,
      ST_EMIT
   } state_type;

   // Operands of the shared adder.
   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             borrow;
   } alu_rsp_type;

   typedef struct packed {
      logic [TAB_W-1:0] tab_width;
      logic [CLR_W-1:0] default_fg;
      logic [CLR_W-1:0] default_bg;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] char_code;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [CLR_W-1:0]  fg_color;
      logic [CLR_W-1:0]  bg_color;
      logic              underline;
      logic              last;
   } emit_type;

   function automatic logic [CLR_W-1:0] colour_of(input logic [REM_W-1:0] digit);
      colour_of = (digit >= 4'd1 && digit <= 4'd7) ? digit[CLR_W-1:0] : 3'd0;
   endfunction

   function automatic logic is_printable(input logic [BYTE_W-1:0] b);
      is_printable = (b >= 8'h20 && b <= 8'h7E) || (b >= 8'hA0 && b != 8'hAD);
   endfunction

endpackage

// ===== src/aetp_alu.sv =====
// ----------------------------------------------------------------------------
// aetp_alu
// Shared adder and subtractor with borrow out, used by the parser's arithmetic steps.
// ----------------------------------------------------------------------------
module aetp_alu (
   input  aetp_pkg::alu_req_type alu_req,
   output aetp_pkg::alu_rsp_type alu_rsp
);

   logic [aetp_pkg::ALU_W-1:0] b_op;
   logic [aetp_pkg::ALU_W:0]   total;

   // Subtraction is a plus the ones complement of b plus one.
   assign b_op  = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign total = {1'b0, alu_req.a} + {1'b0, b_op} + (aetp_pkg::ALU_W+1)'(alu_req.sub);

   assign alu_rsp.sum    = total[aetp_pkg::ALU_W-1:0];
   assign alu_rsp.borrow = alu_req.sub & ~total[aetp_pkg::ALU_W];

endmodule

// ===== src/aetp_ctl.sv =====
// ----------------------------------------------------------------------------
// aetp_ctl
// Parser sequencer: parse state, cursor, attributes and result generation.
// ----------------------------------------------------------------------------
`include "ansi_escape_terminal_parser_macros.svh"

module aetp_ctl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [aetp_pkg::BYTE_W-1:0]   req_rx_byte,
   input  aetp_pkg::cfg_type             cfg,
   input  logic                          out_free,
   output aetp_pkg::emit_type            emit
);

   aetp_pkg::state_type              state_ff, state_in;
   aetp_pkg::mode_type               mode_ff, mode_in;
   aetp_pkg::kind_type               kind_ff, kind_in;
   logic [aetp_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic [aetp_pkg::BYTE_W-1:0]      char_ff, char_in;
   logic [aetp_pkg::PARAM_W-1:0]     param_ff, param_in;
   logic [aetp_pkg::COL_W-1:0]       col_ff, col_in;
   logic [aetp_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [aetp_pkg::CLR_W-1:0]       fg_ff, fg_in;
   logic [aetp_pkg::CLR_W-1:0]       bg_ff, bg_in;
   logic                             ul_ff, ul_in;
   logic [aetp_pkg::ALU_W-1:0]       acc_ff, acc_in;
   logic [aetp_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [2:0]                       bit_ff, bit_in;
   logic [aetp_pkg::CNT_W-1:0]       cnt_ff, cnt_in;

   aetp_pkg::alu_req_type            alu_req;
   aetp_pkg::alu_rsp_type            alu_rsp;
   logic [aetp_pkg::TAB_W-1:0]       tab_w;
   logic [aetp_pkg::REM_W:0]         div_sh;
   logic                             is_digit;
   logic [aetp_pkg::ALU_W-1:0]       row_max_x;
   logic [aetp_pkg::ALU_W-1:0]       col_max_x;

   aetp_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // Tab widths outside 1 to 16 are folded into that range.
   assign tab_w = (cfg.tab_width == '0) ? aetp_pkg::TAB_W'(1) :
                  (cfg.tab_width > aetp_pkg::TAB_W'(aetp_pkg::TAB_MAX)) ?
                  aetp_pkg::TAB_W'(aetp_pkg::TAB_MAX) : cfg.tab_width;

   // Partial remainder of column mod tab width, one column bit per step.
   assign div_sh    = {rem_ff, col_ff[bit_ff]};
   assign is_digit  = (byte_ff >= aetp_pkg::CH_ZERO) && (byte_ff <= aetp_pkg::CH_NINE);
   assign row_max_x = aetp_pkg::ALU_W'(aetp_pkg::ROW_MAX);
   assign col_max_x = aetp_pkg::ALU_W'(aetp_pkg::COL_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aetp_pkg::ST_IDLE;
         mode_ff  <= aetp_pkg::MODE_TEXT;
         param_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         fg_ff    <= aetp_pkg::DEFAULT_FG_RST;
         bg_ff    <= aetp_pkg::DEFAULT_BG_RST;
         ul_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         param_ff <= param_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
         ul_ff    <= ul_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      char_ff <= char_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
   end

   // Operand selection for the shared adder.
   always_comb begin
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      case (state_ff)
         aetp_pkg::ST_DECODE: begin
            case (mode_ff)
               aetp_pkg::MODE_TEXT: begin
                  if (byte_ff == aetp_pkg::CH_LF) begin
                     alu_req.a = aetp_pkg::ALU_W'(row_ff);
                     alu_req.b = aetp_pkg::ALU_W'(1);
                  end else if (byte_ff == aetp_pkg::CH_BS) begin
                     alu_req.a   = aetp_pkg::ALU_W'(col_ff);
                     alu_req.b   = aetp_pkg::ALU_W'(1);
                     alu_req.sub = 1'b1;
                  end
               end
               aetp_pkg::MODE_CSI: begin
                  if (byte_ff == aetp_pkg::CH_SEMI || byte_ff == aetp_pkg::CH_SGR) begin
                     alu_req.a   = aetp_pkg::ALU_W'(param_ff);
                     alu_req.b   = (param_ff < aetp_pkg::PARAM_W'(40)) ?
                                   aetp_pkg::ALU_W'(30) : aetp_pkg::ALU_W'(40);
                     alu_req.sub = 1'b1;
                  end else if (byte_ff == aetp_pkg::CH_UP ||
                               byte_ff == aetp_pkg::CH_DOWN) begin
                     alu_req.a   = aetp_pkg::ALU_W'(row_ff);
                     alu_req.b   = aetp_pkg::ALU_W'(param_ff);
                     alu_req.sub = (byte_ff == aetp_pkg::CH_UP);
                  end else if (byte_ff == aetp_pkg::CH_RIGHT ||
                               byte_ff == aetp_pkg::CH_LEFT) begin
                     alu_req.a   = aetp_pkg::ALU_W'(col_ff);
                     alu_req.b   = aetp_pkg::ALU_W'(param_ff);
                     alu_req.sub = (byte_ff == aetp_pkg::CH_LEFT);
                  end
               end
               default: begin
                  alu_req.a = '0;
               end
            endcase
         end
         aetp_pkg::ST_MUL: begin
            alu_req.a = aetp_pkg::ALU_W'({param_ff, 3'b000});
            alu_req.b = aetp_pkg::ALU_W'({param_ff, 1'b0});
         end
         aetp_pkg::ST_ADD: begin
            alu_req.a = acc_ff;
            alu_req.b = aetp_pkg::ALU_W'(byte_ff[3:0]);
         end
         aetp_pkg::ST_DIV: begin
            alu_req.a   = aetp_pkg::ALU_W'(div_sh);
            alu_req.b   = aetp_pkg::ALU_W'(tab_w);
            alu_req.sub = 1'b1;
         end
         aetp_pkg::ST_TABCNT: begin
            alu_req.a   = aetp_pkg::ALU_W'(tab_w);
            alu_req.b   = aetp_pkg::ALU_W'(rem_ff);
            alu_req.sub = 1'b1;
         end
         aetp_pkg::ST_EMIT: begin
            alu_req.a = aetp_pkg::ALU_W'(col_ff);
            alu_req.b = aetp_pkg::ALU_W'(1);
         end
         default: begin
            alu_req.a = '0;
         end
      endcase
   end

   // Sequencer: next state, parser state updates and result generation.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      char_in  = char_ff;
      param_in = param_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      ul_in    = ul_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      req_ready = 1'b0;

      emit.valid     = 1'b0;
      emit.kind      = kind_ff;
      emit.char_code = char_ff;
      emit.column    = col_ff;
      emit.row       = row_ff;
      emit.fg_color  = fg_ff;
      emit.bg_color  = bg_ff;
      emit.underline = ul_ff;
      emit.last      = (cnt_ff == aetp_pkg::CNT_W'(1));

      case (state_ff)
         aetp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in  = req_rx_byte;
               state_in = aetp_pkg::ST_DECODE;
            end
         end

         aetp_pkg::ST_DECODE: begin
            state_in = aetp_pkg::ST_IDLE;
            case (mode_ff)
               aetp_pkg::MODE_TEXT: begin
                  if (byte_ff == aetp_pkg::CH_ESC) begin
                     mode_in = aetp_pkg::MODE_ESC;
                  end else if (byte_ff == aetp_pkg::CH_CR) begin
                     col_in = '0;
                  end else if (byte_ff == aetp_pkg::CH_LF) begin
                     col_in = '0;
                     row_in = (alu_rsp.sum >= row_max_x) ?
                              aetp_pkg::ROW_W'(aetp_pkg::ROW_MAX) :
                              alu_rsp.sum[aetp_pkg::ROW_W-1:0];
                  end else if (byte_ff == aetp_pkg::CH_BS) begin
                     col_in = alu_rsp.borrow ? '0 : alu_rsp.sum[aetp_pkg::COL_W-1:0];
                  end else if (byte_ff == aetp_pkg::CH_TAB) begin
                     rem_in   = '0;
                     bit_in   = 3'd7;
                     state_in = aetp_pkg::ST_DIV;
                  end else if (aetp_pkg::is_printable(byte_ff)) begin
                     kind_in  = aetp_pkg::KIND_WRITE;
                     char_in  = byte_ff;
                     cnt_in   = aetp_pkg::CNT_W'(1);
                     state_in = aetp_pkg::ST_EMIT;
                  end
               end
               aetp_pkg::MODE_ESC: begin
                  param_in = '0;
                  if (byte_ff == aetp_pkg::CH_LBRACK) begin
                     mode_in = aetp_pkg::MODE_CSI;
                  end else if (byte_ff == aetp_pkg::CH_LPAREN) begin
                     mode_in = aetp_pkg::MODE_CHARSET;
                  end else begin
                     mode_in = aetp_pkg::MODE_TEXT;
                  end
               end
               aetp_pkg::MODE_CSI: begin
                  if (is_digit) begin
                     state_in = aetp_pkg::ST_MUL;
                  end else if (byte_ff == aetp_pkg::CH_SEMI ||
                               byte_ff == aetp_pkg::CH_SGR) begin
                     // Select graphic rendition with the parameter so far.
                     if (param_ff == '0) begin
                        fg_in = cfg.default_fg;
                        bg_in = cfg.default_bg;
                        ul_in = 1'b0;
                     end else if (param_ff == aetp_pkg::PARAM_W'(4)) begin
                        ul_in = 1'b1;
                     end else if (param_ff == aetp_pkg::PARAM_W'(7)) begin
                        fg_in = bg_ff;
                        bg_in = fg_ff;
                     end else if (param_ff >= aetp_pkg::PARAM_W'(30) &&
                                  param_ff <= aetp_pkg::PARAM_W'(39)) begin
                        fg_in = aetp_pkg::colour_of(alu_rsp.sum[aetp_pkg::REM_W-1:0]);
                     end else if (param_ff >= aetp_pkg::PARAM_W'(40) &&
                                  param_ff <= aetp_pkg::PARAM_W'(49)) begin
                        bg_in = aetp_pkg::colour_of(alu_rsp.sum[aetp_pkg::REM_W-1:0]);
                     end
                     if (byte_ff == aetp_pkg::CH_SEMI) begin
                        param_in = '0;
                     end else begin
                        mode_in = aetp_pkg::MODE_TEXT;
                     end
                  end else begin
                     mode_in = aetp_pkg::MODE_TEXT;
                     if (byte_ff == aetp_pkg::CH_J) begin
                        kind_in  = aetp_pkg::KIND_TRUNC;
                        char_in  = aetp_pkg::CH_NULL;
                        cnt_in   = aetp_pkg::CNT_W'(1);
                        state_in = aetp_pkg::ST_EMIT;
                     end else if (byte_ff == aetp_pkg::CH_K) begin
                        kind_in  = aetp_pkg::KIND_CLEAR;
                        char_in  = aetp_pkg::CH_NULL;
                        cnt_in   = aetp_pkg::CNT_W'(1);
                        state_in = aetp_pkg::ST_EMIT;
                     end else if (byte_ff == aetp_pkg::CH_UP) begin
                        row_in = alu_rsp.borrow ? '0 : alu_rsp.sum[aetp_pkg::ROW_W-1:0];
                     end else if (byte_ff == aetp_pkg::CH_DOWN) begin
                        row_in = (alu_rsp.sum >= row_max_x) ?
                                 aetp_pkg::ROW_W'(aetp_pkg::ROW_MAX) :
                                 alu_rsp.sum[aetp_pkg::ROW_W-1:0];
                     end else if (byte_ff == aetp_pkg::CH_RIGHT) begin
                        col_in = (alu_rsp.sum >= col_max_x) ?
                                 aetp_pkg::COL_W'(aetp_pkg::COL_MAX) :
                                 alu_rsp.sum[aetp_pkg::COL_W-1:0];
                     end else if (byte_ff == aetp_pkg::CH_LEFT) begin
                        col_in = alu_rsp.borrow ? '0 : alu_rsp.sum[aetp_pkg::COL_W-1:0];
                     end
                  end
               end
               aetp_pkg::MODE_CHARSET: begin
                  fg_in   = cfg.default_fg;
                  bg_in   = cfg.default_bg;
                  ul_in   = 1'b0;
                  mode_in = aetp_pkg::MODE_TEXT;
               end
               default: begin
                  mode_in = aetp_pkg::MODE_TEXT;
               end
            endcase
         end

         // Parameter times ten as eight times plus two times.
         aetp_pkg::ST_MUL: begin
            acc_in   = alu_rsp.sum;
            state_in = aetp_pkg::ST_ADD;
         end

         aetp_pkg::ST_ADD: begin
            param_in = (alu_rsp.sum > aetp_pkg::ALU_W'(aetp_pkg::PARAM_MAX)) ?
                       aetp_pkg::PARAM_W'(aetp_pkg::PARAM_MAX) :
                       alu_rsp.sum[aetp_pkg::PARAM_W-1:0];
            state_in = aetp_pkg::ST_IDLE;
         end

         // Restoring division step; only the remainder is kept.
         aetp_pkg::ST_DIV: begin
            rem_in = alu_rsp.borrow ? div_sh[aetp_pkg::REM_W-1:0] :
                                      alu_rsp.sum[aetp_pkg::REM_W-1:0];
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = aetp_pkg::ST_TABCNT;
            end
         end

         aetp_pkg::ST_TABCNT: begin
            cnt_in   = alu_rsp.sum[aetp_pkg::CNT_W-1:0];
            kind_in  = aetp_pkg::KIND_WRITE;
            char_in  = aetp_pkg::CH_SPACE;
            state_in = aetp_pkg::ST_EMIT;
         end

         aetp_pkg::ST_EMIT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               cnt_in     = cnt_ff - aetp_pkg::CNT_W'(1);
               if (kind_ff == aetp_pkg::KIND_WRITE) begin
                  col_in = (alu_rsp.sum >= col_max_x) ?
                           aetp_pkg::COL_W'(aetp_pkg::COL_MAX) :
                           alu_rsp.sum[aetp_pkg::COL_W-1:0];
               end
               if (cnt_ff == aetp_pkg::CNT_W'(1)) begin
                  state_in = aetp_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = aetp_pkg::ST_IDLE;
         end
      endcase
   end

   `AETP_ASSERT_IMP(a_emit_needs_slot, emit.valid, out_free, "result emitted into a full output register")
   `AETP_ASSERT_IMP(a_emit_count, state_ff == aetp_pkg::ST_EMIT, cnt_ff != '0, "emit state with no results left")
   `AETP_ASSERT_IMP(a_col_limit, 1'b1, col_ff <= aetp_pkg::COL_W'(aetp_pkg::COL_MAX), "cursor column beyond limit")
   `AETP_ASSERT_IMP(a_row_limit, 1'b1, row_ff <= aetp_pkg::ROW_W'(aetp_pkg::ROW_MAX), "cursor row beyond limit")
   `AETP_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == aetp_pkg::ST_DECODE, "accepted byte not decoded")

endmodule

// ===== src/ansi_escape_terminal_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_terminal_parser
// VT100/ANSI escape sequence parser producing character and line commands.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the req_ channel, one byte per transaction. Each
// byte produces zero or more result transactions on the rsp_ channel:
// character writes with the current cursor position and attributes, line
// clear and line truncate commands. rsp_last marks the final result of a byte.
// The csr_ port writes tab_width, default_fg and default_bg; writes take
// effect at once and are meant to happen while no byte is in flight.
// Timing: req_ready is high only while the parser is waiting for a byte. A
// plain byte passes the decode state; a printable byte or a J/K command then
// goes to the emit state, and its result is valid in the output register on
// the cycle after it is emitted. A CSI parameter digit passes the multiply
// and add states (times ten, then add, through the one shared adder). A tab
// runs the division state on column mod tab_width, one column bit per cycle
// via the same adder, then the space count state, then emits up to 16 spaces.
// If the receiver stalls, the pending result waits in the output register
// and the sequencer holds until that register frees up.
// Reset clears the cursor, the parameter and the parse mode, restores the
// register defaults and the default colors, and empties the output register.
// ----------------------------------------------------------------------------
module ansi_escape_terminal_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [aetp_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [aetp_pkg::BYTE_W-1:0]         rsp_char_code,
   output logic [aetp_pkg::COL_W-1:0]          rsp_column,
   output logic [aetp_pkg::ROW_W-1:0]          rsp_row,
   output logic [aetp_pkg::CLR_W-1:0]          rsp_fg_color,
   output logic [aetp_pkg::CLR_W-1:0]          rsp_bg_color,
   output logic                                rsp_underline,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [aetp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aetp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   aetp_pkg::cfg_type   cfg_ff, cfg_in;
   aetp_pkg::emit_type  emit;
   logic                out_free;

   // Output register: valid flag plus the payload of one result transaction.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [1:0]                        rsp_kind_ff;
   logic [aetp_pkg::BYTE_W-1:0]       rsp_char_ff;
   logic [aetp_pkg::COL_W-1:0]        rsp_col_ff;
   logic [aetp_pkg::ROW_W-1:0]        rsp_row_ff;
   logic [aetp_pkg::CLR_W-1:0]        rsp_fg_ff;
   logic [aetp_pkg::CLR_W-1:0]        rsp_bg_ff;
   logic                              rsp_ul_ff;
   logic                              rsp_last_ff;

   // Configuration registers; an index past the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            aetp_pkg::CSR_TAB_WIDTH:  cfg_in.tab_width  = csr_wdata;
            aetp_pkg::CSR_DEFAULT_FG: cfg_in.default_fg = csr_wdata[aetp_pkg::CLR_W-1:0];
            aetp_pkg::CSR_DEFAULT_BG: cfg_in.default_bg = csr_wdata[aetp_pkg::CLR_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tab_width  <= aetp_pkg::TAB_WIDTH_RST;
         cfg_ff.default_fg <= aetp_pkg::DEFAULT_FG_RST;
         cfg_ff.default_bg <= aetp_pkg::DEFAULT_BG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer may load a new result when the register is empty or
   // its current transaction completes in this cycle.
   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid_in = emit.valid | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_kind_ff <= emit.kind;
         rsp_char_ff <= emit.char_code;
         rsp_col_ff  <= emit.column;
         rsp_row_ff  <= emit.row;
         rsp_fg_ff   <= emit.fg_color;
         rsp_bg_ff   <= emit.bg_color;
         rsp_ul_ff   <= emit.underline;
         rsp_last_ff <= emit.last;
      end
   end

   aetp_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .out_free    (out_free),
      .emit        (emit)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_column    = rsp_col_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_fg_color  = rsp_fg_ff;
   assign rsp_bg_color  = rsp_bg_ff;
   assign rsp_underline = rsp_ul_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
